/* design/mm4_pkg.sv */
// Shared constants for the 4x4 fixed-point matrix multiply unit.
`default_nettype none

package mm4_pkg;

   // Default element format: signed Q16.16.
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Matrix geometry.
   localparam int DIM    = 4;
   localparam int DIM_W  = $clog2(DIM);
   localparam int CELLS  = DIM * DIM;
   localparam int CELL_W = $clog2(CELLS);

   // One multiply-accumulate step per (cell, k) pair.
   localparam int STEPS  = CELLS * DIM;
   localparam int STEP_W = $clog2(STEPS);

   // Two operand banks, so one matrix can load while another is computed.
   localparam int BANKS  = 2;
   localparam int BANK_W = $clog2(BANKS);
   localparam int ADDR_W = BANK_W + CELL_W;

   // The job queue holds one token per loaded bank.
   localparam int QUEUE_DEPTH = BANKS;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage : mm4_pkg

`default_nettype wire

/* design/mm4_operand_store.sv */
// Two-bank operand memories for the left and right matrices.
`default_nettype none

module mm4_operand_store
   import mm4_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire        [ADDR_W-1:0]       wr_addr,
   input  wire        [ELEM_WIDTH-1:0]   wr_left,
   input  wire        [ELEM_WIDTH-1:0]   wr_right,
   input  wire                           rd_en,
   input  wire        [ADDR_W-1:0]       rd_left_addr,
   input  wire        [ADDR_W-1:0]       rd_right_addr,
   output logic signed [ELEM_WIDTH-1:0]  rd_left,
   output logic signed [ELEM_WIDTH-1:0]  rd_right
);

   localparam int DEPTH = BANKS * CELLS;

   logic [ELEM_WIDTH-1:0] left_mem  [DEPTH];
   logic [ELEM_WIDTH-1:0] right_mem [DEPTH];

   // Both memories are written together from the loader.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= wr_left;
         right_mem[wr_addr] <= wr_right;
      end
   end

   // Registered reads for the engine; data holds while the engine stalls.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_left  <= left_mem[rd_left_addr];
         rd_right <= right_mem[rd_right_addr];
      end
   end

endmodule : mm4_operand_store

`default_nettype wire

/* design/mm4_loader.sv */
// Front end: accepts operand transactions and fills one bank per matrix.
`default_nettype none

module mm4_loader
   import mm4_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire  [ELEM_WIDTH-1:0]    in_left,
   input  wire  [ELEM_WIDTH-1:0]    in_right,
   input  wire                      bank_release,
   output logic                     wr_en,
   output logic [ADDR_W-1:0]        wr_addr,
   output logic [ELEM_WIDTH-1:0]    wr_left,
   output logic [ELEM_WIDTH-1:0]    wr_right,
   output logic                     job_push,
   output logic [BANK_W-1:0]        job_bank
);

   localparam int FREE_W = $clog2(BANKS + 1);

   logic [CELL_W-1:0] count_ff, count_in;
   logic [BANK_W-1:0] bank_ff, bank_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic              accept;
   logic              matrix_done;

   // A transaction is taken only while a bank is free to load into.
   assign in_ready    = (free_ff != '0);
   assign accept      = in_valid && in_ready;
   assign matrix_done = accept && (count_ff == CELL_W'(CELLS - 1));

   assign wr_en    = accept;
   assign wr_addr  = {bank_ff, count_ff};
   assign wr_left  = in_left;
   assign wr_right = in_right;
   assign job_push = matrix_done;
   assign job_bank = bank_ff;

   // Load position, bank selection and free-bank credits.
   always_comb begin
      count_in = count_ff;
      bank_in  = bank_ff;
      free_in  = free_ff;
      if (accept) begin
         count_in = count_ff + 1'b1;
      end
      if (matrix_done) begin
         bank_in = bank_ff + 1'b1;
      end
      if (matrix_done && !bank_release) begin
         free_in = free_ff - 1'b1;
      end else if (!matrix_done && bank_release) begin
         free_in = free_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= '0;
         free_ff  <= FREE_W'(BANKS);
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
         free_ff  <= free_in;
      end
   end

endmodule : mm4_loader

`default_nettype wire

/* design/mm4_job_queue.sv */
// Small queue of loaded-bank tokens between the loader and the engine.
`default_nettype none

module mm4_job_queue
   import mm4_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  wire  [BANK_W-1:0]  push_bank,
   input  wire                pop,
   output logic               not_empty,
   output logic [BANK_W-1:0]  head_bank
);

   logic [BANK_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign head_bank = entry_ff[rd_ptr_ff];

   // Token storage; the credit scheme in the loader keeps pushes within depth.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bank;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule : mm4_job_queue

`default_nettype wire

/* design/mm4_engine.sv */
// Back end: shared multiply-accumulate pipeline, rounding, saturation and output.
`default_nettype none

module mm4_engine
   import mm4_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          job_ready,
   input  wire         [BANK_W-1:0]     job_bank,
   output logic                         job_pop,
   output logic                         bank_release,
   output logic                         rd_en,
   output logic        [ADDR_W-1:0]     rd_left_addr,
   output logic        [ADDR_W-1:0]     rd_right_addr,
   input  wire  signed [ELEM_WIDTH-1:0] rd_left,
   input  wire  signed [ELEM_WIDTH-1:0] rd_right,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic signed [ELEM_WIDTH-1:0] out_product,
   output logic                         out_saturated,
   output logic                         out_last
);

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ELEM_WIDTH-1:0] MAX_VAL = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic signed [ELEM_WIDTH-1:0] MIN_VAL = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   logic                busy_ff, busy_in;
   logic [BANK_W-1:0]   bank_ff, bank_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                advance;
   logic                issue;
   logic                last_step;
   logic [CELL_W-1:0]   cell_idx;
   logic [DIM_W-1:0]    k_idx;

   // Read stage tags.
   logic v1_ff, first1_ff, last1_ff, end1_ff;
   // Multiply stage.
   logic v2_ff, first2_ff, last2_ff, end2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   // Accumulate stage.
   logic done3_ff, end3_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   // Output register.
   logic                         rsp_valid_ff;
   logic signed [ELEM_WIDTH-1:0] rsp_product_ff, rsp_product_in;
   logic                         rsp_sat_ff, rsp_sat_in;
   logic                         rsp_last_ff;

   logic signed [ACC_W-1:0]      shifted;
   logic [ACC_W-ELEM_WIDTH:0]    upper;

   // The whole pipeline moves when the output register is empty or being taken.
   assign advance   = !rsp_valid_ff || out_ready;
   assign issue     = busy_ff && advance;
   assign last_step = (step_ff == STEP_W'(STEPS - 1));
   assign cell_idx  = step_ff[STEP_W-1:DIM_W];
   assign k_idx     = step_ff[DIM_W-1:0];

   // Right operand walks row r of its matrix, left operand walks column c.
   assign rd_en         = issue;
   assign rd_right_addr = {bank_ff, cell_idx[CELL_W-1:DIM_W], k_idx};
   assign rd_left_addr  = {bank_ff, k_idx, cell_idx[DIM_W-1:0]};

   assign job_pop      = !busy_ff && job_ready;
   assign bank_release = issue && last_step;

   // Step sequencer over one bank.
   always_comb begin
      busy_in = busy_ff;
      bank_in = bank_ff;
      step_in = step_ff;
      if (job_pop) begin
         busy_in = 1'b1;
         bank_in = job_bank;
         step_in = '0;
      end else if (issue) begin
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      bank_ff <= bank_in;
      step_ff <= step_in;
   end

   // Accumulation: the first term of a cell replaces the running sum.
   always_comb begin
      acc_in = acc_ff;
      if (v2_ff) begin
         if (first2_ff) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Drop the fraction (floor) and clamp to the element range.
   assign shifted = acc_ff >>> FRAC_BITS;
   assign upper   = shifted[ACC_W-1:ELEM_WIDTH-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         rsp_product_in = shifted[ELEM_WIDTH-1:0];
         rsp_sat_in     = 1'b0;
      end else begin
         rsp_product_in = shifted[ACC_W-1] ? MIN_VAL : MAX_VAL;
         rsp_sat_in     = 1'b1;
      end
   end

   // Pipeline registers, all held while the output is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         done3_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         done3_ff     <= v2_ff && last2_ff;
         rsp_valid_ff <= done3_ff;
      end
      if (advance) begin
         first1_ff      <= (k_idx == '0);
         last1_ff       <= (k_idx == DIM_W'(DIM - 1));
         end1_ff        <= last_step;
         first2_ff      <= first1_ff;
         last2_ff       <= last1_ff;
         end2_ff        <= end1_ff;
         prod_ff        <= PROD_W'(rd_right) * PROD_W'(rd_left);
         acc_ff         <= acc_in;
         end3_ff        <= end2_ff;
         rsp_product_ff <= rsp_product_in;
         rsp_sat_ff     <= rsp_sat_in;
         rsp_last_ff    <= end3_ff;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_product   = rsp_product_ff;
   assign out_saturated = rsp_sat_ff;
   assign out_last      = rsp_last_ff;

endmodule : mm4_engine

`default_nettype wire

/* design/matrix4x4_multiply_unit.sv */
// Top level of the 4x4 fixed-point matrix multiply unit.
//
// The unit takes sixteen request transactions per matrix pair, in row-major order, each
// carrying one left and one right element (signed fixed point, FRAC_BITS fraction bits).
// After the sixteenth it returns sixteen response transactions in row-major order with
// P[r][c] = sum over k of right[r][k] * left[k][c]; the sum is kept at full width, shifted
// right by FRAC_BITS (rounding toward minus infinity) and clamped to the element range,
// with tuser set on a clamped element and tlast on the sixteenth. Loading accepts one request
// per cycle. The engine has one shared multiplier and does one multiply-accumulate per cycle
// while the output is not stalled, 64 steps per matrix, before it takes the next job; the
// reads for each element pass the read, multiply and accumulate stages and then the output
// register, which offers the response.
// Two operand banks let the next matrix load while the current one is computed; requests
// stall only while both banks hold matrices that are waiting for or in computation.
`default_nettype none

module matrix4x4_multiply_unit
   import mm4_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int REQ_TDATA_W = ((2 * ELEM_WIDTH + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((ELEM_WIDTH + 7) / 8) * 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0: left_element, right_element, zero fill.
   input  wire  [REQ_TDATA_W-1:0]   req_tdata,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   // Fields from bit 0: product_element, zero fill.
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,
   // Fields from bit 0: saturated.
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ELEM_WIDTH-1:0]        wr_left;
   logic [ELEM_WIDTH-1:0]        wr_right;
   logic                         job_push;
   logic [BANK_W-1:0]            push_bank;
   logic                         job_pop;
   logic                         job_ready;
   logic [BANK_W-1:0]            head_bank;
   logic                         bank_release;
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_left_addr;
   logic [ADDR_W-1:0]            rd_right_addr;
   logic signed [ELEM_WIDTH-1:0] rd_left;
   logic signed [ELEM_WIDTH-1:0] rd_right;
   logic signed [ELEM_WIDTH-1:0] product;

   // Front end: request intake and bank filling.
   mm4_loader #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_loader (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_left      (req_tdata[ELEM_WIDTH-1:0]),
      .in_right     (req_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
      .bank_release (bank_release),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_left      (wr_left),
      .wr_right     (wr_right),
      .job_push     (job_push),
      .job_bank     (push_bank)
   );

   // Loaded-bank tokens waiting for the engine.
   mm4_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_bank (push_bank),
      .pop       (job_pop),
      .not_empty (job_ready),
      .head_bank (head_bank)
   );

   // Operand memories shared by both ends.
   mm4_operand_store #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_operand_store (
      .clock         (clock),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_left       (wr_left),
      .wr_right      (wr_right),
      .rd_en         (rd_en),
      .rd_left_addr  (rd_left_addr),
      .rd_right_addr (rd_right_addr),
      .rd_left       (rd_left),
      .rd_right      (rd_right)
   );

   // Back end: multiply-accumulate and result delivery.
   mm4_engine #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .job_ready     (job_ready),
      .job_bank      (head_bank),
      .job_pop       (job_pop),
      .bank_release  (bank_release),
      .rd_en         (rd_en),
      .rd_left_addr  (rd_left_addr),
      .rd_right_addr (rd_right_addr),
      .rd_left       (rd_left),
      .rd_right      (rd_right),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_product   (product),
      .out_saturated (rsp_tuser),
      .out_last      (rsp_tlast)
   );

   // Response data with zero fill above the element.
   always_comb begin
      rsp_tdata                 = '0;
      rsp_tdata[ELEM_WIDTH-1:0] = product;
   end

endmodule : matrix4x4_multiply_unit

`default_nettype wire
